// File: src/asc_pkg.sv
package asc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_BITS = 16;
  localparam int IN_W       = 16;
  localparam int COEF_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int PROD_W = COEF_W + IN_W + 1;
  localparam int Z_W    = PROD_W + 1;
  localparam int NUM_W  = Z_W + 2;
  localparam int QB     = COORD_BITS + FRAC_BITS + 2;
  localparam int SH     = QB - FRAC_BITS + 1;
  localparam int T_W    = QB + 3;
  localparam int CMP_W  = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_XX   = 3'd0,
    CFG_COEF_YX   = 3'd1,
    CFG_COEF_XY   = 3'd2,
    CFG_COEF_YY   = 3'd3,
    CFG_OFFSET_X  = 3'd4,
    CFG_OFFSET_Y  = 3'd5,
    CFG_SRC_WIDTH = 3'd6,
    CFG_SRC_HEIGHT = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AX_POS,
    AX_NEG,
    AX_FLAT
  } axis_mode_e;

  typedef struct packed {
    logic signed [IN_W-1:0] row_y;
    logic signed [IN_W-1:0] span_start;
    logic signed [IN_W-1:0] span_end;
  } in_item_t;

  typedef struct packed {
    logic signed [IN_W-1:0] clipped_start;
    logic signed [IN_W-1:0] clipped_end;
  } out_item_t;

  typedef struct packed {
    logic [COEF_W-1:0] rem;
    logic [QB-1:0]     sh;
    logic [COEF_W-1:0] dvs;
    logic              neg;
    logic              ovf;
  } div_t;

  typedef struct packed {
    logic signed [IN_W-1:0] span_start;
    logic signed [IN_W-1:0] span_end;
    axis_mode_e             mode_x;
    axis_mode_e             mode_y;
    logic                   in_x;
    logic                   in_y;
  } side_t;

  // one restoring step: next dividend bit enters, quotient bit shifts in
  function automatic div_t div_step(input div_t d);
    logic [COEF_W:0] tr;
    logic [COEF_W:0] diff;
    logic            ge;
    div_t            r;
    tr   = {d.rem, d.sh[QB-1]};
    diff = tr - {1'b0, d.dvs};
    ge   = !diff[COEF_W];
    r      = d;
    r.rem  = ge ? diff[COEF_W-1:0] : tr[COEF_W-1:0];
    r.sh   = {d.sh[QB-2:0], ge};
    return r;
  endfunction

  function automatic div_t div_init(input logic signed [NUM_W-1:0] num,
                                    input logic [COEF_W-1:0] dvs);
    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] hi;
    div_t             r;
    mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    hi    = mag >> SH;
    r.neg = num[NUM_W-1];
    r.ovf = hi >= NUM_W'(dvs);
    r.rem = hi[COEF_W-1:0];
    r.sh  = {mag[SH-1:0], {(FRAC_BITS-1){1'b0}}};
    r.dvs = dvs;
    return r;
  endfunction

  // ceil((floor(num*2^(F-1)/a) + adj - 2^(F-1)) / 2^F), saturated
  function automatic logic signed [COORD_BITS-1:0] div_bound(input div_t d,
                                                           input logic is_start);
    logic signed [T_W-1:0] q;
    logic signed [T_W-1:0] t;
    logic signed [T_W-1:0] b;
    logic signed [T_W-1:0] hi;
    logic signed [T_W-1:0] lo;
    hi = T_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    lo = T_W'(-(64'sd1 <<< (COORD_BITS - 1)));
    q  = d.neg ? (-$signed(T_W'(d.sh)) - T_W'(d.rem != '0)) : $signed(T_W'(d.sh));
    t  = q + (is_start ? T_W'(1) : -T_W'(1)) - T_W'(64'sd1 <<< (FRAC_BITS - 1));
    b  = -((-t) >>> FRAC_BITS);
    if (d.ovf) begin
      b = d.neg ? lo : hi;
    end
    if (b > hi) begin
      b = hi;
    end else if (b < lo) begin
      b = lo;
    end
    return b[COORD_BITS-1:0];
  endfunction

endpackage

// File: src/affine_span_clip_top.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o  | in_data_i  (row_y, span_start, span_end)
// out     | output    | out_valid_o / out_stall_i| out_data_o (clipped_start, clipped_end)
// cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
// One transaction per cycle while the output is not stalled; the bit-per-stage restoring
// dividers, four of which run side by side, set the pipeline depth.
// Asynchronous active-low reset clears the valid bits and loads register defaults.
// A stall with out_valid_o high freezes the whole pipeline and is returned on in_stall_o.
module affine_span_clip_top
  import asc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  localparam int NV = QB + 5;

  logic signed [COEF_W-1:0] coef_xx_q, coef_yx_q, coef_xy_q, coef_yy_q;
  logic signed [COEF_W-1:0] offset_x_q, offset_y_q;
  logic [SIZE_W-1:0]        src_w_q, src_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q  <= COEF_W'(64'sd1 <<< FRAC_BITS);
      coef_yx_q  <= '0;
      coef_xy_q  <= '0;
      coef_yy_q  <= COEF_W'(64'sd1 <<< FRAC_BITS);
      offset_x_q <= '0;
      offset_y_q <= '0;
      src_w_q    <= '0;
      src_h_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COEF_XX:    coef_xx_q  <= cfg_data_i;
        CFG_COEF_YX:    coef_yx_q  <= cfg_data_i;
        CFG_COEF_XY:    coef_xy_q  <= cfg_data_i;
        CFG_COEF_YY:    coef_yy_q  <= cfg_data_i;
        CFG_OFFSET_X:   offset_x_q <= cfg_data_i;
        CFG_OFFSET_Y:   offset_y_q <= cfg_data_i;
        CFG_SRC_WIDTH:  src_w_q    <= cfg_data_i[SIZE_W-1:0];
        CFG_SRC_HEIGHT: src_h_q    <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic [NV-1:0] v_q;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign out_valid_o = v_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NV-2:0], in_valid_i};
    end
  end

  // stage 1: row products
  in_item_t                 s1_item_q;
  logic signed [PROD_W-1:0] s1_px_q, s1_py_q;
  logic signed [IN_W:0]     row2;

  assign row2 = $signed({in_data_i.row_y, 1'b1});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_item_q <= in_data_i;
      s1_px_q   <= PROD_W'(coef_xy_q) * PROD_W'(row2);
      s1_py_q   <= PROD_W'(coef_yy_q) * PROD_W'(row2);
    end
  end

  // stage 2: row constants, case select, numerators
  logic signed [Z_W-1:0]   zx, zy, sx, sy;
  logic signed [NUM_W-1:0] s2_lox_q, s2_hix_q, s2_loy_q, s2_hiy_q;
  logic [COEF_W-1:0]       s2_ax_q, s2_ay_q;
  side_t                   s2_side_q;

  assign zx = Z_W'(s1_px_q) + (Z_W'(offset_x_q) <<< 1);
  assign zy = Z_W'(s1_py_q) + (Z_W'(offset_y_q) <<< 1);
  assign sx = $signed(Z_W'({1'b0, src_w_q}) << (FRAC_BITS + 1));
  assign sy = $signed(Z_W'({1'b0, src_h_q}) << (FRAC_BITS + 1));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_side_q.span_start <= s1_item_q.span_start;
      s2_side_q.span_end   <= s1_item_q.span_end;
      s2_side_q.in_x       <= !(zx < 0 || zx >= sx);
      s2_side_q.in_y       <= !(zy < 0 || zy >= sy);
      if (coef_xx_q > 1) begin
        s2_side_q.mode_x <= AX_POS;
        s2_lox_q         <= -NUM_W'(zx);
        s2_hix_q         <= NUM_W'(sx) - NUM_W'(zx);
        s2_ax_q          <= coef_xx_q;
      end else if (coef_xx_q < -1) begin
        s2_side_q.mode_x <= AX_NEG;
        s2_lox_q         <= NUM_W'(zx) - NUM_W'(sx);
        s2_hix_q         <= NUM_W'(zx);
        s2_ax_q          <= -coef_xx_q;
      end else begin
        s2_side_q.mode_x <= AX_FLAT;
        s2_lox_q         <= '0;
        s2_hix_q         <= '0;
        s2_ax_q          <= COEF_W'(2);
      end
      if (coef_yx_q > 1) begin
        s2_side_q.mode_y <= AX_POS;
        s2_loy_q         <= -NUM_W'(zy);
        s2_hiy_q         <= NUM_W'(sy) - NUM_W'(zy);
        s2_ay_q          <= coef_yx_q;
      end else if (coef_yx_q < -1) begin
        s2_side_q.mode_y <= AX_NEG;
        s2_loy_q         <= NUM_W'(zy) - NUM_W'(sy);
        s2_hiy_q         <= NUM_W'(zy);
        s2_ay_q          <= -coef_yx_q;
      end else begin
        s2_side_q.mode_y <= AX_FLAT;
        s2_loy_q         <= '0;
        s2_hiy_q         <= '0;
        s2_ay_q          <= COEF_W'(2);
      end
    end
  end

  // stage 3 onward: four restoring dividers; after the init stage, one quotient bit per stage
  div_t  dlx_q [0:QB];
  div_t  dhx_q [0:QB];
  div_t  dly_q [0:QB];
  div_t  dhy_q [0:QB];
  side_t side_q [0:QB];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dlx_q[0]  <= div_init(s2_lox_q, s2_ax_q);
      dhx_q[0]  <= div_init(s2_hix_q, s2_ax_q);
      dly_q[0]  <= div_init(s2_loy_q, s2_ay_q);
      dhy_q[0]  <= div_init(s2_hiy_q, s2_ay_q);
      side_q[0] <= s2_side_q;
      for (int k = 0; k < QB; k++) begin
        dlx_q[k+1]  <= div_step(dlx_q[k]);
        dhx_q[k+1]  <= div_step(dhx_q[k]);
        dly_q[k+1]  <= div_step(dly_q[k]);
        dhy_q[k+1]  <= div_step(dhy_q[k]);
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // bounds
  logic signed [COORD_BITS-1:0] blx_q, bhx_q, bly_q, bhy_q;
  side_t                        bs_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      blx_q <= div_bound(dlx_q[QB], 1'b1);
      bhx_q <= div_bound(dhx_q[QB], 1'b0);
      bly_q <= div_bound(dly_q[QB], 1'b1);
      bhy_q <= div_bound(dhy_q[QB], 1'b0);
      bs_q  <= side_q[QB];
    end
  end

  // narrow and collapse
  logic signed [CMP_W-1:0] x0, x1;
  logic                    collapse;
  out_item_t               res;

  always_comb begin
    x0 = CMP_W'(bs_q.span_start);
    x1 = CMP_W'(bs_q.span_end);
    collapse = (bs_q.mode_x == AX_FLAT && !bs_q.in_x) ||
               (bs_q.mode_y == AX_FLAT && !bs_q.in_y);
    if (bs_q.mode_x != AX_FLAT) begin
      if (CMP_W'(blx_q) > x0) x0 = CMP_W'(blx_q);
      if (CMP_W'(bhx_q) < x1) x1 = CMP_W'(bhx_q);
    end
    if (bs_q.mode_y != AX_FLAT) begin
      if (CMP_W'(bly_q) > x0) x0 = CMP_W'(bly_q);
      if (CMP_W'(bhy_q) < x1) x1 = CMP_W'(bhy_q);
    end
    if (collapse) begin
      res.clipped_start = bs_q.span_start;
      res.clipped_end   = bs_q.span_start;
    end else begin
      res.clipped_start = x0[IN_W-1:0];
      res.clipped_end   = x1[IN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o <= res;
    end
  end

endmodule
